/* design/linear_actuator_homing_positioner_top_defines.svh */
// Assertion macros shared by the homing positioner RTL.
`ifndef LINEAR_ACTUATOR_HOMING_POSITIONER_TOP_DEFINES_SVH
`define LINEAR_ACTUATOR_HOMING_POSITIONER_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define LAHP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define LAHP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* design/lahp_pkg.sv */
package lahp_pkg;

  localparam int POSITION_BITS_DEF = 24;

  // Percent scale and deadband reset
  localparam int unsigned PCT_FULL = 100;
  localparam logic [3:0] DEADBAND_RST = 4'd3;

  // Action selector codes
  localparam logic [2:0] ACT_MANUAL = 3'd0;
  localparam logic [2:0] ACT_AUTO   = 3'd1;
  localparam logic [2:0] ACT_HOME   = 3'd2;
  localparam logic [2:0] ACT_REREF  = 3'd3;

  // Manual request codes
  localparam logic [1:0] MREQ_IN  = 2'd1;
  localparam logic [1:0] MREQ_OUT = 2'd2;

  typedef enum logic [1:0] {
    CMD_STOP = 2'd0,
    CMD_IN   = 2'd1,
    CMD_OUT  = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    HS_START       = 2'd0,
    HS_SEEK_OUTER  = 2'd1,
    HS_SEEK_INNER  = 2'd2,
    HS_RETURN      = 2'd3
  } homing_step_t;

  typedef enum logic [1:0] {
    RS_START      = 2'd0,
    RS_SEEK_OUTER = 2'd1,
    RS_RETRACE    = 2'd2
  } reref_step_t;

  // Sequencer flags exchanged between top level and command logic
  typedef struct packed {
    logic         homing_active;
    homing_step_t homing_step;
    logic         reref_active;
    reref_step_t  reref_step;
    command_t     held;
  } seq_state_t;

  // Top-level control states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } ctrl_state_t;

endpackage

/* design/lahp_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module lahp_div #(
  parameter int NUM_BITS = lahp_pkg::POSITION_BITS_DEF + 6,
  parameter int DEN_BITS = lahp_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output logic                done,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [NUM_BITS-1:0] quo;
  logic [CNT_BITS-1:0] count;
  logic                busy;
  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  // Shift next dividend bit into remainder and try subtracting
  assign shifted = {rem, quo[NUM_BITS-1]};
  assign trial   = shifted - {1'b0, den};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // done rises with the complete quotient, set on the step that shifts in the last bit
      done <= busy && !start && (count == CNT_BITS'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(NUM_BITS);
        rem   <= '0;
        den   <= denom;
        quo   <= numer;
      end else if (busy) begin
        rem   <= fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
        quo   <= {quo[NUM_BITS-2:0], fits};
        count <= count - CNT_BITS'(1);
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* design/lahp_cmd.sv */
// Per-tick command selection: homing and re-reference sequencers, manual and
// deadband control, limit gating and position count update.
module lahp_cmd #(
  parameter int POSITION_BITS = lahp_pkg::POSITION_BITS_DEF
) (
  input  lahp_pkg::seq_state_t       seq,
  input  logic [POSITION_BITS-1:0]   position_count,
  input  logic [POSITION_BITS-1:0]   retrace_count,
  input  logic [POSITION_BITS-1:0]   travel_span,
  input  logic [2:0]                 action,
  input  logic [1:0]                 manual_request,
  input  logic [6:0]                 target_percent,
  input  logic                       outer_limit,
  input  logic                       inner_limit,
  input  logic [3:0]                 deadband,
  input  logic [6:0]                 percent,
  output lahp_pkg::seq_state_t       seq_next,
  output logic [POSITION_BITS-1:0]   position_next,
  output logic [POSITION_BITS-1:0]   retrace_next,
  output logic [POSITION_BITS-1:0]   span_next,
  output logic                       drive_out,
  output logic                       drive_in
);

  logic signed [8:0]          diff;
  logic signed [8:0]          band;
  logic [POSITION_BITS-1:0]   pos_base;

  assign diff = $signed({2'b00, target_percent}) - $signed({2'b00, percent});
  assign band = $signed({5'b00000, deadband});

  always_comb begin
    seq_next     = seq;
    pos_base     = position_count;
    retrace_next = retrace_count;
    span_next    = travel_span;

    if (seq.homing_active) begin
      // Homing: out to outer switch, in to inner switch, back out
      unique case (seq.homing_step)
        lahp_pkg::HS_START: begin
          seq_next.held        = lahp_pkg::CMD_OUT;
          seq_next.homing_step = lahp_pkg::HS_SEEK_OUTER;
        end
        lahp_pkg::HS_SEEK_OUTER: begin
          if (outer_limit) begin
            pos_base             = '0;
            seq_next.held        = lahp_pkg::CMD_IN;
            seq_next.homing_step = lahp_pkg::HS_SEEK_INNER;
          end
        end
        lahp_pkg::HS_SEEK_INNER: begin
          if (inner_limit) begin
            seq_next.held        = lahp_pkg::CMD_OUT;
            span_next            = position_count;
            seq_next.homing_step = lahp_pkg::HS_RETURN;
          end
        end
        lahp_pkg::HS_RETURN: begin
          if (outer_limit) begin
            pos_base               = '0;
            seq_next.held          = lahp_pkg::CMD_STOP;
            seq_next.homing_active = 1'b0;
            seq_next.homing_step   = lahp_pkg::HS_START;
          end
        end
      endcase
    end else if (seq.reref_active) begin
      // Re-reference: count ticks out to the switch, retrace as many inward
      unique case (seq.reref_step)
        lahp_pkg::RS_START: begin
          retrace_next        = '0;
          seq_next.held       = lahp_pkg::CMD_OUT;
          seq_next.reref_step = lahp_pkg::RS_SEEK_OUTER;
        end
        lahp_pkg::RS_SEEK_OUTER: begin
          if (!outer_limit) begin
            retrace_next = retrace_count + POSITION_BITS'(1);
          end else begin
            pos_base            = '0;
            seq_next.held       = lahp_pkg::CMD_IN;
            seq_next.reref_step = lahp_pkg::RS_RETRACE;
          end
        end
        default: begin
          if (retrace_count != '0) begin
            retrace_next = retrace_count - POSITION_BITS'(1);
          end else begin
            seq_next.held         = lahp_pkg::CMD_STOP;
            seq_next.reref_active = 1'b0;
            seq_next.reref_step   = lahp_pkg::RS_START;
          end
        end
      endcase
    end else begin
      // Normal operation selected by action
      unique case (action)
        lahp_pkg::ACT_MANUAL: begin
          unique case (manual_request)
            lahp_pkg::MREQ_IN:  seq_next.held = lahp_pkg::CMD_IN;
            lahp_pkg::MREQ_OUT: seq_next.held = lahp_pkg::CMD_OUT;
            default:            seq_next.held = lahp_pkg::CMD_STOP;
          endcase
        end
        lahp_pkg::ACT_AUTO: begin
          priority if (diff >= band) begin
            seq_next.held = lahp_pkg::CMD_IN;
          end else if (diff <= -band) begin
            seq_next.held = lahp_pkg::CMD_OUT;
          end else begin
            seq_next.held = lahp_pkg::CMD_STOP;
          end
        end
        lahp_pkg::ACT_HOME:  seq_next.homing_active = 1'b1;
        lahp_pkg::ACT_REREF: seq_next.reref_active  = 1'b1;
        default:             seq_next.held = lahp_pkg::CMD_STOP;
      endcase
    end
  end

  // Drive lines gated at the switch in their direction
  assign drive_in  = (seq_next.held == lahp_pkg::CMD_IN) && !inner_limit;
  assign drive_out = (seq_next.held == lahp_pkg::CMD_OUT) && !outer_limit;

  always_comb begin
    position_next = pos_base;
    if (drive_out) position_next = pos_base + POSITION_BITS'(1);
    if (drive_in)  position_next = pos_base - POSITION_BITS'(1);
  end

endmodule

/* design/linear_actuator_homing_positioner_top.sv */
// Linear actuator homing positioner. Each stream transaction on the s_ side
// is one control tick and yields exactly one result transaction on the m_
// side. An accepted tick passes through the MUL, START, DIV and DONE states
// before s_tready rises again, skipping DIV when the travel span is zero; in
// DIV the bit-serial divider scales the position count to percent, one
// quotient bit per cycle. The result sits in an output register, so the next
// tick may be accepted while it waits; if a tick finishes while an earlier
// result still waits there, it holds in the sequencer and s_tready stays low
// until the register frees. After reset the homing sequence runs first. The
// deadband register may be written at any time through cfg_valid/cfg_data
// while no tick is in flight.
`include "linear_actuator_homing_positioner_top_defines.svh"

module linear_actuator_homing_positioner_top #(
  parameter int POSITION_BITS = lahp_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // deadband register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  // tick input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [1:0] manual_request, [8:2] target_percent,
                                // [9] outer_limit, [10] inner_limit
  input  logic [2:0]  s_tuser,  // [2:0] action
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // [1:0] motor_command, [2] drive_out,
                                // [3] drive_in, [10:4] position_percent,
                                // [11] homing_busy, [12] rereference_busy
);

  localparam int NUM_BITS  = POSITION_BITS + 6;
  localparam int PROD_BITS = POSITION_BITS + 7;

  lahp_pkg::ctrl_state_t state;
  lahp_pkg::seq_state_t  seq;
  lahp_pkg::seq_state_t  seq_next;

  logic [3:0]               deadband;
  logic [POSITION_BITS-1:0] position_count;
  logic [POSITION_BITS-1:0] retrace_count;
  logic [POSITION_BITS-1:0] travel_span;
  logic [POSITION_BITS-1:0] position_next;
  logic [POSITION_BITS-1:0] retrace_next;
  logic [POSITION_BITS-1:0] span_next;
  logic [6:0]               percent;
  logic                     drive_out_next;
  logic                     drive_in_next;
  logic                     drive_out;
  logic                     drive_in;

  // Divider operands
  logic signed [PROD_BITS-1:0] pos_ext;
  logic signed [PROD_BITS-1:0] prod;
  logic [PROD_BITS-1:0]        prod_mag;
  logic [POSITION_BITS-1:0]    span_mag;
  logic [NUM_BITS-1:0]         num_op;
  logic [POSITION_BITS-1:0]    den_op;
  logic                        quo_neg;
  logic                        span_zero;
  logic                        div_start;
  logic                        div_done;
  logic [NUM_BITS-1:0]         quotient;

  // Scaled result
  logic [6:0] pct_next;
  logic       out_of_range;
  logic       out_free;

  // Output register
  logic       out_valid;
  logic [1:0] out_cmd;
  logic       out_dout;
  logic       out_din;
  logic [6:0] out_pct;
  logic       out_hbusy;
  logic       out_rbusy;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == lahp_pkg::ST_IDLE);
  assign out_free  = !out_valid || m_tready;

  lahp_cmd #(
    .POSITION_BITS(POSITION_BITS)
  ) u_cmd (
    .seq            (seq),
    .position_count (position_count),
    .retrace_count  (retrace_count),
    .travel_span    (travel_span),
    .action         (s_tuser),
    .manual_request (s_tdata[1:0]),
    .target_percent (s_tdata[8:2]),
    .outer_limit    (s_tdata[9]),
    .inner_limit    (s_tdata[10]),
    .deadband       (deadband),
    .percent        (percent),
    .seq_next       (seq_next),
    .position_next  (position_next),
    .retrace_next   (retrace_next),
    .span_next      (span_next),
    .drive_out      (drive_out_next),
    .drive_in       (drive_in_next)
  );

  // position * 100 as shift-add, then magnitudes for the divider
  assign pos_ext  = PROD_BITS'($signed(position_count));
  assign prod     = (pos_ext <<< 6) + (pos_ext <<< 5) + (pos_ext <<< 2);
  assign prod_mag = prod[PROD_BITS-1] ? PROD_BITS'(-prod) : prod;
  assign span_mag = travel_span[POSITION_BITS-1] ? -travel_span : travel_span;

  assign div_start = (state == lahp_pkg::ST_START) && !span_zero;

  lahp_div #(
    .NUM_BITS(NUM_BITS),
    .DEN_BITS(POSITION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (num_op),
    .denom    (den_op),
    .done     (div_done),
    .quotient (quotient)
  );

  // Saturate quotient; negative or above full scale flags re-reference
  always_comb begin
    pct_next     = '0;
    out_of_range = 1'b0;
    priority if (span_zero || quotient == '0) begin
      pct_next = '0;
    end else if (quo_neg) begin
      out_of_range = 1'b1;
    end else if (quotient > NUM_BITS'(lahp_pkg::PCT_FULL)) begin
      pct_next     = 7'(lahp_pkg::PCT_FULL);
      out_of_range = 1'b1;
    end else begin
      pct_next = quotient[6:0];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= lahp_pkg::DEADBAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      deadband <= cfg_data;
    end
  end

  // Tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state                   <= lahp_pkg::ST_IDLE;
      seq.homing_active       <= 1'b1;
      seq.homing_step         <= lahp_pkg::HS_START;
      seq.reref_active        <= 1'b0;
      seq.reref_step          <= lahp_pkg::RS_START;
      seq.held                <= lahp_pkg::CMD_STOP;
      position_count          <= '0;
      retrace_count           <= '0;
      travel_span             <= POSITION_BITS'(lahp_pkg::PCT_FULL);
      percent                 <= '0;
      out_valid               <= 1'b0;
    end else begin
      // load a finished tick, else drop a result once taken
      if ((state == lahp_pkg::ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        lahp_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            seq            <= seq_next;
            position_count <= position_next;
            retrace_count  <= retrace_next;
            travel_span    <= span_next;
            drive_out      <= drive_out_next;
            drive_in       <= drive_in_next;
            state          <= lahp_pkg::ST_MUL;
          end
        end
        lahp_pkg::ST_MUL: begin
          num_op    <= prod_mag[NUM_BITS-1:0];
          den_op    <= span_mag;
          quo_neg   <= position_count[POSITION_BITS-1] ^ travel_span[POSITION_BITS-1];
          span_zero <= (travel_span == '0);
          state     <= lahp_pkg::ST_START;
        end
        lahp_pkg::ST_START: begin
          state <= span_zero ? lahp_pkg::ST_DONE : lahp_pkg::ST_DIV;
        end
        lahp_pkg::ST_DIV: begin
          if (div_done) begin
            state <= lahp_pkg::ST_DONE;
          end
        end
        lahp_pkg::ST_DONE: begin
          if (out_free) begin
            percent   <= pct_next;
            out_cmd   <= seq.held;
            out_dout  <= drive_out;
            out_din   <= drive_in;
            out_pct   <= pct_next;
            out_hbusy <= seq.homing_active;
            out_rbusy <= seq.reref_active || (out_of_range && !seq.homing_active);
            if (out_of_range && !seq.homing_active) begin
              seq.reref_active <= 1'b1;
            end
            state <= lahp_pkg::ST_IDLE;
          end
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_rbusy, out_hbusy, out_pct, out_din, out_dout, out_cmd};

  // Checks
  `LAHP_ASSERT_NEVER(a_both_drives, m_tvalid && out_dout && out_din, "both drive lines set")
  `LAHP_ASSERT_NEVER(a_two_sequences, seq.homing_active && seq.reref_active,
                     "homing and re-reference active together")
  `LAHP_ASSERT_IMP(a_pct_range, m_tvalid, out_pct <= 7'(lahp_pkg::PCT_FULL),
                   "position percent above full scale")
  `LAHP_ASSERT_IMP(a_div_done_state, div_done, state == lahp_pkg::ST_DIV,
                   "divider finished outside divide state")

endmodule

/* dv/lahp_tick_checker.sv */
// Passive checker for the homing positioner: mirrors the control state,
// predicts one result per accepted tick and compares it with what the
// block returns on the m_ side.
module lahp_tick_checker #(
  parameter int POSITION_BITS = lahp_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] manual_request, [8:2] target_percent,
                                 // [9] outer_limit, [10] inner_limit
  input  logic [2:0]  s_tuser,   // [2:0] action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [1:0] motor_command, [2] drive_out,
                                 // [3] drive_in, [10:4] position_percent,
                                 // [11] homing_busy, [12] rereference_busy
  output int          fail_count,
  output int          results_due
);

  localparam longint FULL_SCALE = longint'(lahp_pkg::PCT_FULL);
  localparam int MAX_SHOWN = 10;

  // One result transaction, lowest field last
  typedef struct packed {
    logic               reref_busy;
    logic               homing_busy;
    logic [6:0]         pct;
    logic               drive_in;
    logic               drive_out;
    lahp_pkg::command_t cmd;
  } tick_result_t;

  // Mirrored control state
  logic [3:0]                      deadband_q;
  logic                            homing_on;
  lahp_pkg::homing_step_t          home_step;
  logic                            reref_on;
  lahp_pkg::reref_step_t           reref_stage;
  logic signed [POSITION_BITS-1:0] count_q;
  logic signed [POSITION_BITS-1:0] span_q;
  logic [POSITION_BITS-1:0]        retrace_q;
  logic [7:0]                      pct_q;
  lahp_pkg::command_t              held_q;

  tick_result_t expected_ticks[$];

  // Advance the mirrored state by one control tick and form its result
  task automatic step_positioner(input logic [2:0] act, input logic [1:0] mreq,
                                 input logic [6:0] tgt, input logic outer,
                                 input logic inner, output tick_result_t res);
    longint q;
    int     err;
    logic   dout;
    logic   din;
    if (homing_on) begin
      case (home_step)
        lahp_pkg::HS_START: begin
          held_q = lahp_pkg::CMD_OUT;
          home_step = lahp_pkg::HS_SEEK_OUTER;
        end
        lahp_pkg::HS_SEEK_OUTER: if (outer) begin
          count_q = '0;
          held_q = lahp_pkg::CMD_IN;
          home_step = lahp_pkg::HS_SEEK_INNER;
        end
        lahp_pkg::HS_SEEK_INNER: if (inner) begin
          held_q = lahp_pkg::CMD_OUT;
          span_q = count_q;
          home_step = lahp_pkg::HS_RETURN;
        end
        default: if (outer) begin
          count_q = '0;
          held_q = lahp_pkg::CMD_STOP;
          homing_on = 1'b0;
          home_step = lahp_pkg::HS_START;
        end
      endcase
    end else if (reref_on) begin
      case (reref_stage)
        lahp_pkg::RS_START: begin
          retrace_q = '0;
          held_q = lahp_pkg::CMD_OUT;
          reref_stage = lahp_pkg::RS_SEEK_OUTER;
        end
        lahp_pkg::RS_SEEK_OUTER: if (!outer) begin
          retrace_q = retrace_q + POSITION_BITS'(1);
        end else begin
          count_q = '0;
          held_q = lahp_pkg::CMD_IN;
          reref_stage = lahp_pkg::RS_RETRACE;
        end
        default: if (retrace_q != 0) begin
          retrace_q = retrace_q - POSITION_BITS'(1);
        end else begin
          held_q = lahp_pkg::CMD_STOP;
          reref_on = 1'b0;
          reref_stage = lahp_pkg::RS_START;
        end
      endcase
    end else begin
      case (act)
        lahp_pkg::ACT_MANUAL: begin
          case (mreq)
            lahp_pkg::MREQ_IN:  held_q = lahp_pkg::CMD_IN;
            lahp_pkg::MREQ_OUT: held_q = lahp_pkg::CMD_OUT;
            default:            held_q = lahp_pkg::CMD_STOP;
          endcase
        end
        lahp_pkg::ACT_AUTO: begin
          err = int'(tgt) - int'(pct_q);
          if (err >= int'(deadband_q)) held_q = lahp_pkg::CMD_IN;
          else if (err <= -int'(deadband_q)) held_q = lahp_pkg::CMD_OUT;
          else held_q = lahp_pkg::CMD_STOP;
        end
        lahp_pkg::ACT_HOME:  homing_on = 1'b1;
        lahp_pkg::ACT_REREF: reref_on = 1'b1;
        default:             held_q = lahp_pkg::CMD_STOP;
      endcase
    end

    // drive lines are gated at the switch in their direction
    dout = (held_q == lahp_pkg::CMD_OUT) && !outer;
    din = (held_q == lahp_pkg::CMD_IN) && !inner;
    if (dout) count_q = count_q + POSITION_BITS'(1);
    if (din) count_q = count_q - POSITION_BITS'(1);

    // scale to percent, truncating toward zero; saturation forces re-reference
    if (span_q == 0) q = 0;
    else q = (longint'(count_q) * FULL_SCALE) / longint'(span_q);
    if (q > FULL_SCALE) begin
      q = FULL_SCALE;
      if (!homing_on) reref_on = 1'b1;
    end else if (q < 0) begin
      q = 0;
      if (!homing_on) reref_on = 1'b1;
    end
    pct_q = q[7:0];

    res.cmd = held_q;
    res.drive_out = dout;
    res.drive_in = din;
    res.pct = pct_q[6:0];
    res.homing_busy = homing_on;
    res.reref_busy = reref_on;
  endtask

  task automatic note_field(input string what, input logic [7:0] want_v,
                            input logic [7:0] got_v);
    if (got_v !== want_v) begin
      if (fail_count < MAX_SHOWN)
        $display("checker: %s mismatch at %0t, expected %0d, got %0d",
                 what, $time, want_v, got_v);
      fail_count++;
    end
  endtask

  // Monitor all three channels on the rising edge
  always @(posedge clk) begin : monitor
    tick_result_t want;
    tick_result_t got;
    if (rst) begin
      deadband_q = lahp_pkg::DEADBAND_RST;
      homing_on = 1'b1;
      home_step = lahp_pkg::HS_START;
      reref_on = 1'b0;
      reref_stage = lahp_pkg::RS_START;
      count_q = '0;
      span_q = POSITION_BITS'(FULL_SCALE);
      retrace_q = '0;
      pct_q = '0;
      held_q = lahp_pkg::CMD_STOP;
      fail_count = 0;
      expected_ticks.delete();
    end else begin
      if (cfg_valid && cfg_ready) deadband_q = cfg_data;

      // compare before pushing so a stray result never meets a fresh entry
      if (m_tvalid && m_tready) begin
        got = m_tdata[12:0];
        if (expected_ticks.size() == 0) begin
          if (fail_count < MAX_SHOWN)
            $display("checker: result transaction at %0t with none pending", $time);
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          note_field("motor_command", 8'(want.cmd), 8'(got.cmd));
          note_field("drive_out", 8'(want.drive_out), 8'(got.drive_out));
          note_field("drive_in", 8'(want.drive_in), 8'(got.drive_in));
          note_field("position_percent", 8'(want.pct), 8'(got.pct));
          note_field("homing_busy", 8'(want.homing_busy), 8'(got.homing_busy));
          note_field("rereference_busy", 8'(want.reref_busy), 8'(got.reref_busy));
        end
      end

      if (s_tvalid && s_tready) begin
        step_positioner(s_tuser, s_tdata[1:0], s_tdata[8:2], s_tdata[9],
                        s_tdata[10], want);
        expected_ticks.push_back(want);
      end
    end
    results_due = expected_ticks.size();
  end

endmodule

/* dv/tb.sv */
// Stimulus and verdict for the homing positioner. A small actuator model
// turns the returned drive lines into limit switch levels for random ticks.
module tb;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_TICKS = 650;
  localparam int HOLD_CYCLES = 600;

  // codes the package leaves unnamed
  localparam logic [2:0] ACT_STOP_MIN = 3'd4;
  localparam logic [1:0] MREQ_STOP = 2'd0;
  localparam logic [1:0] MREQ_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [1:0] manual_request, [8:2] target_percent,
                          // [9] outer_limit, [10] inner_limit
  logic [2:0]  s_tuser;   // [2:0] action
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [1:0] motor_command, [2] drive_out, [3] drive_in,
                          // [10:4] position_percent, [11] homing_busy,
                          // [12] rereference_busy

  int fail_count;
  int results_due;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit pressure_armed = 1'b0;
  int hold_left = 0;
  int plant_x = 0;
  int plant_len = 20;
  int cycle_count = 0;

  always #2 clk = ~clk;

  linear_actuator_homing_positioner_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  lahp_tick_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // Actuator model: moves one step per returned drive line, stops at the ends
  always @(posedge clk) begin : plant_model
    int nx;
    if (m_tvalid && m_tready) begin
      nx = plant_x + int'(m_tdata[2]) - int'(m_tdata[3]);
      if (nx > plant_len) nx = plant_len;
      if (nx < 0) nx = 0;
      plant_x <= nx;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random back-pressure plus one long hold once armed
  initial begin : rx_side
    int  arm_wait;
    bit  pressure_done;
    arm_wait = 200;
    pressure_done = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_armed && !pressure_done) begin
        if (arm_wait == 0) begin
          hold_left = HOLD_CYCLES;
          pressure_done = 1'b1;
        end else begin
          arm_wait--;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one tick and wait for its transaction; returns on a falling edge
  task automatic send_tick(input logic [2:0] act, input logic [1:0] mreq,
                           input logic [6:0] tgt, input logic outer,
                           input logic inner);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {5'b0, inner, outer, tgt, mreq};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random tick; limits mostly follow the actuator model, sometimes noise
  task automatic random_tick();
    logic [2:0] act;
    logic [1:0] mreq;
    logic [6:0] tgt;
    logic       outer;
    logic       inner;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 35) act = lahp_pkg::ACT_MANUAL;
    else if (r < 80) act = lahp_pkg::ACT_AUTO;
    else if (r < 83) act = lahp_pkg::ACT_HOME;
    else if (r < 87) act = lahp_pkg::ACT_REREF;
    else act = 3'($urandom_range(int'(ACT_STOP_MIN), 7));
    mreq = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) tgt = 7'($urandom_range(101, 127));
    else tgt = 7'($urandom_range(0, 100));

    // usually let the previous result reach the model first
    if ($urandom_range(0, 99) < 80 && results_due != 0 && hold_left == 0) begin
      s_tvalid <= 1'b0;
      while (results_due != 0 && hold_left == 0) @(negedge clk);
    end
    outer = (plant_x >= plant_len);
    inner = (plant_x <= 0);
    if ($urandom_range(0, 99) < 8) outer = 1'($urandom);
    if ($urandom_range(0, 99) < 8) inner = 1'($urandom);
    send_tick(act, mreq, tgt, outer, inner);
  endtask

  task automatic write_deadband(input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int k;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    write_deadband(4'd0);

    // homing straight into both switches leaves a zero span
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_AUTO, lahp_pkg::MREQ_IN, 7'd100, 1'b1, 1'b1);
    send_tick(lahp_pkg::ACT_MANUAL, lahp_pkg::MREQ_OUT, 7'd0, 1'b1, 1'b1);
    send_tick(lahp_pkg::ACT_REREF, lahp_pkg::MREQ_IN, 7'd0, 1'b1, 1'b0);
    // manual requests, zero span keeps percent at 0
    send_tick(lahp_pkg::ACT_MANUAL, lahp_pkg::MREQ_IN, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, lahp_pkg::MREQ_OUT, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_NONE, 7'd0, 1'b0, 1'b0);
    // deadband zero with zero error drives in; then top target at inner stop
    send_tick(lahp_pkg::ACT_AUTO, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_AUTO, MREQ_STOP, 7'd127, 1'b0, 1'b1);
    // undefined actions stop
    for (k = 0; k < 4; k++)
      send_tick(ACT_STOP_MIN + 3'(k), MREQ_NONE, 7'd127, 1'b1, 1'b1);
    // short re-reference
    send_tick(lahp_pkg::ACT_REREF, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b1, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    // homing with a short negative span
    send_tick(lahp_pkg::ACT_HOME, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b1, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b0, 1'b1);
    send_tick(lahp_pkg::ACT_MANUAL, MREQ_STOP, 7'd0, 1'b1, 1'b0);
    // walk in past the span: saturates above range and re-references
    send_tick(lahp_pkg::ACT_MANUAL, lahp_pkg::MREQ_IN, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, lahp_pkg::MREQ_IN, 7'd0, 1'b0, 1'b0);
    send_tick(lahp_pkg::ACT_MANUAL, lahp_pkg::MREQ_IN, 7'd0, 1'b0, 1'b0);
    s_tvalid <= 1'b0;
    wait_idle();

    // sender idles lightly, receiver heavily
    write_deadband(4'd15);
    tx_idle_pct = 17;
    rx_idle_pct = 46;
    plant_len = $urandom_range(6, 40);
    repeat (PHASE_TICKS) random_tick();
    s_tvalid <= 1'b0;
    wait_idle();

    // the other way round
    write_deadband(4'($urandom_range(1, 14)));
    tx_idle_pct = 46;
    rx_idle_pct = 17;
    plant_len = $urandom_range(6, 40);
    repeat (PHASE_TICKS) random_tick();
    s_tvalid <= 1'b0;
    wait_idle();

    // no idling, one long receiver hold while ticks keep coming
    write_deadband(4'd0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    plant_len = $urandom_range(6, 40);
    pressure_armed = 1'b1;
    repeat (PHASE_TICKS) random_tick();
    s_tvalid <= 1'b0;
    wait_idle();

    if (fail_count == 0 && results_due == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
